// File: hdl/bfbp_pkg.sv
// ----------------------------------------------------------------------------
// bfbp_pkg
// Shared types and constants of the best-fit buffer pool.
// ----------------------------------------------------------------------------
package bfbp_pkg;

  localparam int REQ_SIZE_W = 26;
  localparam int HANDLE_W   = 6;
  localparam int BYTES_W    = 27;
  localparam int STATUS_W   = 3;
  localparam int COUNT_W    = 7;
  localparam int TOTAL_W    = 32;
  localparam int STAMP_W    = 32;

  // Sizes are kept in units of 512 bytes.
  localparam int UNIT_SHIFT = 9;
  localparam int UNIT_ROUND = 511;

  localparam logic REQ_GET  = 1'b0;
  localparam logic REQ_FREE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_REUSED   = 3'd0,
    ST_NEW      = 3'd1,
    ST_FULL     = 3'd2,
    ST_FREED    = 3'd3,
    ST_BAD_FREE = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_FREE_RD,
    S_FREE_CHK,
    S_RESP
  } state_t;

  typedef struct packed {
    logic clear;
    logic cand_valid;
  } fit_ctrl_t;

endpackage

// File: hdl/bfbp_req_if.sv
// ----------------------------------------------------------------------------
// bfbp_req_if
// Request channel of the buffer pool: get or free, with valid and ready.
// ----------------------------------------------------------------------------
interface bfbp_req_if import bfbp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  req_type;
  logic [REQ_SIZE_W-1:0] req_size;
  logic [HANDLE_W-1:0]   free_handle;

  modport source (output valid, req_type, req_size, free_handle, input ready);
  modport sink   (input valid, req_type, req_size, free_handle, output ready);
endinterface

// File: hdl/bfbp_rsp_if.sv
// ----------------------------------------------------------------------------
// bfbp_rsp_if
// Response channel of the buffer pool: one response per request.
// ----------------------------------------------------------------------------
interface bfbp_rsp_if import bfbp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [HANDLE_W-1:0] slot_handle;
  logic [BYTES_W-1:0]  granted_bytes;
  status_t             status;
  logic [COUNT_W-1:0]  buffer_count;
  logic [TOTAL_W-1:0]  total_bytes;

  modport source (output valid, slot_handle, granted_bytes, status, buffer_count,
                  total_bytes, input ready);
  modport sink   (input valid, slot_handle, granted_bytes, status, buffer_count,
                  total_bytes, output ready);
endinterface

// File: hdl/bfbp_fit_unit.sv
// ----------------------------------------------------------------------------
// bfbp_fit_unit
// Best-fit compare unit: takes one slot per cycle and keeps the best so far.
// ----------------------------------------------------------------------------
module bfbp_fit_unit import bfbp_pkg::*; #(
  parameter int UW = 18,
  parameter int IW = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  fit_ctrl_t          ctrl,
  input  logic [UW-1:0]      want,
  input  logic [IW-1:0]      cand_idx,
  input  logic               cand_free,
  input  logic [UW-1:0]      cand_units,
  input  logic [STAMP_W-1:0] cand_stamp,
  output logic               found,
  output logic [IW-1:0]      best_idx,
  output logic [UW-1:0]      best_units,
  output logic [STAMP_W-1:0] best_stamp
);

  logic eligible;
  logic better;

  // With the request size fixed, the smallest excess is the smallest slot.
  // A tie goes to the slot freed most recently.
  assign eligible = ctrl.cand_valid && cand_free && (cand_units >= want);
  assign better   = !found || (cand_units < best_units) ||
                    ((cand_units == best_units) && (cand_stamp > best_stamp));

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctrl.clear) begin
      found <= 1'b0;
    end else if (eligible && better) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!ctrl.clear && eligible && better) begin
      best_idx   <= cand_idx;
      best_units <= cand_units;
      best_stamp <= cand_stamp;
    end
  end

endmodule

// File: hdl/best_fit_buffer_pool.sv
// ----------------------------------------------------------------------------
// best_fit_buffer_pool
// Best-fit pool of buffer slots with get and free requests.
// ----------------------------------------------------------------------------
// A request on req either gets a buffer of req_size bytes, rounded up to a
// multiple of 512 bytes, or frees the slot named by free_handle. Every request
// gives exactly one response on rsp, in order.
// A get scans the opened slots through one compare unit, one slot a cycle
// from the slot memory, then takes the best fitting free slot or, if there
// is room, a new one. A free reads the named slot and rewrites it if the
// free is good. The next request is taken the cycle after the response is
// loaded into the output register; none is taken while one is in progress.
// The output register lets a new request in while the last response still
// waits; a further response waits in its final state until rsp is ready.
// Reset clears the slot count, byte total and free counter; the slot
// memory needs no clearing, as only slots already opened are ever read.
// ----------------------------------------------------------------------------
module best_fit_buffer_pool import bfbp_pkg::*; #(
  parameter int NUM_SLOTS = 64,
  parameter int SIZE_BITS = 26
) (
  input  logic          clk,
  input  logic          rst,
  bfbp_req_if.sink      req,
  bfbp_rsp_if.source    rsp
);

  localparam int EFF = (SIZE_BITS < REQ_SIZE_W) ? SIZE_BITS : REQ_SIZE_W;
  localparam int UW  = EFF + 1 - UNIT_SHIFT;
  localparam int IW  = $clog2(NUM_SLOTS);
  localparam int CW  = $clog2(NUM_SLOTS + 1);
  localparam int HCW = (CW > HANDLE_W) ? CW : HANDLE_W;

  typedef struct packed {
    logic               free;
    logic [STAMP_W-1:0] stamp;
    logic [UW-1:0]      units;
  } slot_t;

  state_t state, state_next;

  logic [CW-1:0]      opened;
  logic [TOTAL_W-1:0] total;
  logic [STAMP_W-1:0] free_counter;
  logic [CW-1:0]      idx;
  logic [UW-1:0]      want;
  logic [HANDLE_W-1:0] handle;

  slot_t              mem [NUM_SLOTS];
  slot_t              rd_q;
  logic [IW-1:0]      rd_addr;
  logic               mem_we;
  logic [IW-1:0]      wr_addr;
  slot_t              wr_data;

  logic               cand_v;
  logic [IW-1:0]      cand_i;
  fit_ctrl_t          fit_ctrl;
  logic               found;
  logic [IW-1:0]      best_idx;
  logic [UW-1:0]      best_units;
  logic [STAMP_W-1:0] best_stamp;

  logic               accept;
  logic               scan_issue;
  logic               full;
  logic [HCW-1:0]     handle_ext;
  logic               handle_ok;
  logic               bad_free;
  logic               out_room;
  logic               load_out;

  logic [EFF:0]        rounded;
  logic [TOTAL_W:0]    total_sum;
  logic [HANDLE_W-1:0] res_handle;
  logic [BYTES_W-1:0]  res_bytes;
  status_t             res_status;
  logic [TOTAL_W-1:0]  total_bytes_now;

  logic                out_valid;
  logic [HANDLE_W-1:0] out_handle;
  logic [BYTES_W-1:0]  out_bytes;
  status_t             out_status;
  logic [COUNT_W-1:0]  out_count;
  logic [TOTAL_W-1:0]  out_total;

  assign req.ready  = (state == S_IDLE);
  assign accept     = req.valid && req.ready;
  assign scan_issue = (state == S_SCAN) && (idx < opened);
  assign full       = (opened == CW'(NUM_SLOTS));
  assign handle_ext = HCW'(handle);
  assign handle_ok  = handle_ext < HCW'(opened);
  assign bad_free   = !handle_ok || rd_q.free;
  assign out_room   = !out_valid || rsp.ready;
  assign rounded    = (EFF+1)'(req.req_size[EFF-1:0]) + (EFF+1)'(UNIT_ROUND);
  assign total_sum  = (TOTAL_W+1)'(total) + (TOTAL_W+1)'(want);

  assign total_bytes_now = (|total[TOTAL_W-1:TOTAL_W-UNIT_SHIFT]) ? '1 :
                           {total[TOTAL_W-1-UNIT_SHIFT:0], {UNIT_SHIFT{1'b0}}};

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (req.req_type == REQ_FREE) ? S_FREE_RD : S_SCAN;
        end
      end
      S_SCAN: begin
        if (idx >= opened) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE:   state_next = S_RESP;
      S_FREE_RD:  state_next = S_FREE_CHK;
      S_FREE_CHK: state_next = S_RESP;
      S_RESP: begin
        if (out_room) begin
          state_next = S_IDLE;
        end
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    fit_ctrl.clear      = accept;
    fit_ctrl.cand_valid = cand_v;
    mem_we              = 1'b0;
    wr_addr             = '0;
    wr_data             = '0;
    rd_addr             = '0;
    load_out            = 1'b0;
    unique case (state)
      S_IDLE: ;
      S_SCAN: begin
        if (scan_issue) begin
          rd_addr = idx[IW-1:0];
        end
      end
      S_DECIDE: begin
        if (found) begin
          mem_we  = 1'b1;
          wr_addr = best_idx;
          wr_data = '{free: 1'b0, stamp: best_stamp, units: best_units};
        end else if (!full) begin
          mem_we  = 1'b1;
          wr_addr = opened[IW-1:0];
          wr_data = '{free: 1'b0, stamp: '0, units: want};
        end
      end
      S_FREE_RD: begin
        if (handle_ok) begin
          rd_addr = handle_ext[IW-1:0];
        end
      end
      S_FREE_CHK: begin
        if (!bad_free) begin
          mem_we  = 1'b1;
          wr_addr = handle_ext[IW-1:0];
          wr_data = '{free: 1'b1, stamp: free_counter, units: rd_q.units};
        end
      end
      S_RESP:  load_out = out_room;
      default: ;
    endcase
  end

  // Slot memory with a registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  bfbp_fit_unit #(
    .UW (UW),
    .IW (IW)
  ) u_fit (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (fit_ctrl),
    .want       (want),
    .cand_idx   (cand_i),
    .cand_free  (rd_q.free),
    .cand_units (rd_q.units),
    .cand_stamp (rd_q.stamp),
    .found      (found),
    .best_idx   (best_idx),
    .best_units (best_units),
    .best_stamp (best_stamp)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      opened       <= '0;
      total        <= '0;
      free_counter <= '0;
      idx          <= '0;
      cand_v       <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state  <= state_next;
      cand_v <= scan_issue;
      if (accept) begin
        idx <= '0;
      end else if (scan_issue) begin
        idx <= idx + 1'b1;
      end
      if (state == S_DECIDE && !found && !full) begin
        opened <= opened + 1'b1;
        total  <= total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
      end
      if (state == S_FREE_CHK && !bad_free) begin
        free_counter <= free_counter + 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request fields, result and output register.
  always_ff @(posedge clk) begin
    cand_i <= idx[IW-1:0];
    if (accept) begin
      want   <= rounded[EFF:UNIT_SHIFT];
      handle <= req.free_handle;
    end
    if (state == S_DECIDE) begin
      if (found) begin
        res_handle <= HANDLE_W'(best_idx);
        res_bytes  <= BYTES_W'({best_units, {UNIT_SHIFT{1'b0}}});
        res_status <= ST_REUSED;
      end else if (full) begin
        res_handle <= '0;
        res_bytes  <= '0;
        res_status <= ST_FULL;
      end else begin
        res_handle <= HANDLE_W'(opened);
        res_bytes  <= BYTES_W'({want, {UNIT_SHIFT{1'b0}}});
        res_status <= ST_NEW;
      end
    end
    if (state == S_FREE_CHK) begin
      res_handle <= handle;
      if (bad_free) begin
        res_bytes  <= '0;
        res_status <= ST_BAD_FREE;
      end else begin
        res_bytes  <= BYTES_W'({rd_q.units, {UNIT_SHIFT{1'b0}}});
        res_status <= ST_FREED;
      end
    end
    if (load_out) begin
      out_handle <= res_handle;
      out_bytes  <= res_bytes;
      out_status <= res_status;
      out_count  <= COUNT_W'(opened);
      out_total  <= total_bytes_now;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.slot_handle   = out_handle;
  assign rsp.granted_bytes = out_bytes;
  assign rsp.status        = out_status;
  assign rsp.buffer_count  = out_count;
  assign rsp.total_bytes   = out_total;

  // The pool never opens more slots than it has.
  a_opened_bound: assert property (@(posedge clk) disable iff (rst)
    opened <= CW'(NUM_SLOTS))
    else $error("slot count beyond pool size");

  // A get that finds no fitting free slot in a pool with room opens one.
  a_open_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE && !found && !full) |=> (opened == $past(opened) + 1'b1))
    else $error("new slot not counted");

  // The free counter moves only on a good free.
  a_stamp_step: assert property (@(posedge clk) disable iff (rst)
    (free_counter != $past(free_counter)) |->
      ($past(state) == S_FREE_CHK && !$past(bad_free)))
    else $error("free counter moved without a free");

  // The byte total never shrinks.
  a_total_mono: assert property (@(posedge clk) disable iff (rst)
    total >= $past(total))
    else $error("byte total decreased");

endmodule

// File: tb/tb_best_fit_buffer_pool.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_best_fit_buffer_pool
// Self-checking bench for the best-fit buffer pool.
// ----------------------------------------------------------------------------
// A queue of requests feeds a clocked driver. Each request is scored by a
// behavioural copy of the pool at the moment it is accepted, and the reply it
// should give is queued. A clocked monitor pops the oldest expected reply for
// every response and compares it field by field. Both sides insert random
// gaps. A directed opening covers the edge cases; random traffic follows,
// a mix of frees of slots in use and gets of mixed sizes, some near opened slots.
// ----------------------------------------------------------------------------
module tb_best_fit_buffer_pool;
  import bfbp_pkg::*;

  localparam int POOL_SLOTS   = 64;
  localparam int UNITS_W      = BYTES_W - UNIT_SHIFT;
  localparam int RANDOM_ITEMS = 1430;
  localparam int TAIL_CYCLES  = POOL_SLOTS + 16;
  localparam int MAX_REPORTS  = 40;
  localparam int MAX_SIZE     = (1 << REQ_SIZE_W) - 1;

  typedef struct packed {
    logic                  req_type;
    logic [REQ_SIZE_W-1:0] req_size;
    logic [HANDLE_W-1:0]   free_handle;
  } pool_req_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] slot_handle;
    logic [BYTES_W-1:0]  granted_bytes;
    status_t             status;
    logic [COUNT_W-1:0]  buffer_count;
    logic [TOTAL_W-1:0]  total_bytes;
  } pool_reply_t;

  logic clk;
  logic rst;

  bfbp_req_if req ();
  bfbp_rsp_if rsp ();

  best_fit_buffer_pool dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  // Shadow of the pool, advanced once per accepted request.
  logic [UNITS_W-1:0] pool_units [POOL_SLOTS];
  bit                 pool_is_free [POOL_SLOTS];
  logic [STAMP_W-1:0] pool_stamp [POOL_SLOTS];
  int unsigned        pool_opened = 0;
  logic [31:0]        unit_total  = '0;
  logic [STAMP_W-1:0] free_tally  = '0;

  pool_req_t   requests_queued [$];
  pool_reply_t replies_due [$];
  pool_req_t   req_in_flight;
  pool_reply_t reply_wanted;

  int mismatches = 0;
  int send_gap   = 0;
  int send_calm  = 0;
  int recv_stall = 0;
  int recv_calm  = 0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic pool_reply_t serve_pool_request(pool_req_t q);
    pool_reply_t        a;
    logic [BYTES_W-1:0] rounded;
    logic [UNITS_W-1:0] want;
    logic [UNITS_W-1:0] diff;
    logic [UNITS_W-1:0] best_diff;
    logic [32:0]        sum;
    int                 best;
    bit                 found;
    a = '0;
    if (q.req_type == REQ_GET) begin
      rounded   = BYTES_W'(q.req_size) + BYTES_W'(UNIT_ROUND);
      want      = rounded[BYTES_W-1:UNIT_SHIFT];
      found     = 1'b0;
      best      = 0;
      best_diff = '0;
      for (int i = 0; i < pool_opened; i++) begin
        if (pool_is_free[i] && pool_units[i] >= want) begin
          diff = pool_units[i] - want;
          // Equal excess goes to the slot with the larger stamp.
          if (!found || diff < best_diff ||
              (diff == best_diff && pool_stamp[i] > pool_stamp[best])) begin
            found     = 1'b1;
            best      = i;
            best_diff = diff;
          end
        end
      end
      if (found) begin
        pool_is_free[best] = 1'b0;
        a.slot_handle   = HANDLE_W'(best);
        a.granted_bytes = {pool_units[best], {UNIT_SHIFT{1'b0}}};
        a.status        = ST_REUSED;
      end else if (pool_opened >= POOL_SLOTS) begin
        a.status = ST_FULL;
      end else begin
        pool_units[pool_opened]   = want;
        pool_is_free[pool_opened] = 1'b0;
        a.slot_handle   = HANDLE_W'(pool_opened);
        a.granted_bytes = {want, {UNIT_SHIFT{1'b0}}};
        a.status        = ST_NEW;
        pool_opened++;
        sum        = {1'b0, unit_total} + 33'(want);
        unit_total = sum[32] ? '1 : sum[31:0];
      end
    end else begin
      a.slot_handle = q.free_handle;
      if (q.free_handle >= pool_opened || pool_is_free[q.free_handle]) begin
        a.status = ST_BAD_FREE;
      end else begin
        pool_is_free[q.free_handle] = 1'b1;
        pool_stamp[q.free_handle]   = free_tally;
        free_tally++;
        a.granted_bytes = {pool_units[q.free_handle], {UNIT_SHIFT{1'b0}}};
        a.status        = ST_FREED;
      end
    end
    a.buffer_count = COUNT_W'(pool_opened);
    a.total_bytes  = (unit_total[31:TOTAL_W-UNIT_SHIFT] != 0) ? '1 :
                     {unit_total[TOTAL_W-UNIT_SHIFT-1:0], {UNIT_SHIFT{1'b0}}};
    return a;
  endfunction

  function automatic pool_req_t make_get(int unsigned size);
    pool_req_t q;
    q.req_type    = REQ_GET;
    q.req_size    = REQ_SIZE_W'(size);
    q.free_handle = HANDLE_W'($urandom());
    return q;
  endfunction

  function automatic pool_req_t make_free(int unsigned handle);
    pool_req_t q;
    q.req_type    = REQ_FREE;
    q.req_size    = REQ_SIZE_W'($urandom());
    q.free_handle = HANDLE_W'(handle);
    return q;
  endfunction

  // Frees of slots in use, more often as more are in use, and gets of mixed
  // sizes, some near the size of an opened slot, with some frees of arbitrary handles as noise.
  function automatic pool_req_t pick_random_request();
    int          in_use [$];
    int          r;
    int unsigned sz;
    int unsigned off;
    int unsigned src;
    for (int i = 0; i < pool_opened; i++) begin
      if (!pool_is_free[i]) in_use.push_back(i);
    end
    r = $urandom_range(0, 99);
    if (r < 8) return make_free($urandom_range(0, POOL_SLOTS - 1));
    if ($urandom_range(0, POOL_SLOTS - 1) < in_use.size())
      return make_free(in_use[$urandom_range(0, in_use.size() - 1)]);
    r = $urandom_range(0, 99);
    if (r < 20) begin
      sz = $urandom_range(0, 2047);
    end else if (r < 50 && pool_opened > 0) begin
      src = $urandom_range(0, pool_opened - 1);
      sz  = pool_units[src] << UNIT_SHIFT;
      off = $urandom_range(0, 1023);
      sz  = (sz > off) ? sz - off : 0;
      if (sz > MAX_SIZE) sz = MAX_SIZE;
    end else if (r < 75) begin
      sz = $urandom_range(0, 1 << 20);
    end else if (r < 90) begin
      sz = $urandom_range(0, MAX_SIZE);
    end else begin
      sz = $urandom_range(MAX_SIZE - 511, MAX_SIZE);
    end
    return make_get(sz);
  endfunction

  // Mostly short gaps, a few long ones, and now and then a calm stretch.
  function automatic int pick_pause(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic check_field(string what, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s expected %0d actual %0d", $time, what, want_v, got_v);
    end
  endtask

  task automatic wait_for_drain();
    while (requests_queued.size() != 0 || req.valid || replies_due.size() != 0)
      @(negedge clk);
  endtask

  // Request driver.
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (req.valid && req.ready) begin
        replies_due.push_back(serve_pool_request(req_in_flight));
        send_gap = pick_pause(send_calm);
      end
      if (!req.valid || req.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          req.valid <= 1'b0;
        end else if (requests_queued.size() > 0) begin
          req_in_flight = requests_queued.pop_front();
          req.valid       <= 1'b1;
          req.req_type    <= req_in_flight.req_type;
          req.req_size    <= req_in_flight.req_size;
          req.free_handle <= req_in_flight.free_handle;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor and back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (replies_due.size() == 0) begin
          mismatches++;
          $display("%0t: response with none expected, handle %0d status %0d",
                   $time, rsp.slot_handle, rsp.status);
        end else begin
          reply_wanted = replies_due.pop_front();
          check_field("slot_handle", 32'(reply_wanted.slot_handle), 32'(rsp.slot_handle));
          check_field("granted_bytes", 32'(reply_wanted.granted_bytes),
                      32'(rsp.granted_bytes));
          check_field("status", 32'(reply_wanted.status), 32'(rsp.status));
          check_field("buffer_count", 32'(reply_wanted.buffer_count),
                      32'(rsp.buffer_count));
          check_field("total_bytes", reply_wanted.total_bytes, rsp.total_bytes);
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
        // Stall after a response, and sometimes while waiting for one.
        if ((rsp.valid && rsp.ready) || $urandom_range(0, 15) == 0)
          recv_stall = pick_pause(recv_calm);
      end
    end
  end

  initial begin
    rst             = 1'b1;
    req.valid       = 1'b0;
    req.req_type    = REQ_GET;
    req.req_size    = '0;
    req.free_handle = '0;
    rsp.ready       = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Opening sequence: bad frees, rounding, zero size, ties and best fit.
    requests_queued.push_back(make_free(0));
    requests_queued.push_back(make_get(0));
    requests_queued.push_back(make_get(1));
    requests_queued.push_back(make_get(512));
    requests_queued.push_back(make_get(513));
    requests_queued.push_back(make_get(MAX_SIZE));
    requests_queued.push_back(make_free(POOL_SLOTS - 1));
    requests_queued.push_back(make_free(1));
    requests_queued.push_back(make_free(2));
    requests_queued.push_back(make_free(2));
    requests_queued.push_back(make_get(100));
    requests_queued.push_back(make_get(0));
    requests_queued.push_back(make_free(4));
    requests_queued.push_back(make_free(0));
    requests_queued.push_back(make_get(0));
    requests_queued.push_back(make_free(3));
    requests_queued.push_back(make_get(700));
    requests_queued.push_back(make_get(MAX_SIZE - 510));
    requests_queued.push_back(make_get(MAX_SIZE));
    requests_queued.push_back(make_get(1023));
    requests_queued.push_back(make_free(6));
    requests_queued.push_back(make_free(5));
    requests_queued.push_back(make_get(1025));

    // Hold the sender until every reply is back.
    wait_for_drain();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) wait_for_drain();
      // Keep the queue short so that frees follow the pool as it stands.
      while (requests_queued.size() >= 2) @(negedge clk);
      requests_queued.push_back(pick_random_request());
    end

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
